@@ rtl/lcmu_pkg.sv @@
// ----------------------------------------------------------------------------
// lcmu_pkg
// Shared types and constants for the lighting color MAC unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lcmu_pkg;

  typedef enum logic [3:0] {
    CMD_WRITE    = 4'd0,
    CMD_READ     = 4'd1,
    CMD_LIGHT    = 4'd2,
    CMD_CMATRIX  = 4'd3,
    CMD_MODULATE = 4'd4,
    CMD_FARCOLOR = 4'd5,
    CMD_SHIFT    = 4'd6,
    CMD_PUSH     = 4'd7,
    CMD_INTERP   = 4'd8
  } cmd_e;

  localparam int unsigned RI_LM   = 0;
  localparam int unsigned RI_CM   = 9;
  localparam int unsigned RI_BK   = 18;
  localparam int unsigned RI_FC   = 21;
  localparam int unsigned RI_V0   = 24;
  localparam int unsigned RI_IR0  = 27;
  localparam int unsigned RI_IR   = 28;
  localparam int unsigned RI_MAC  = 31;
  localparam int unsigned RI_RGB  = 34;
  localparam int unsigned RI_QUEUE = 35;

  localparam logic signed [63:0] MacHi = 64'sh0000_07FF_FFFF_FFFF;
  localparam logic signed [63:0] MacLo = -64'sh0000_0800_0000_0000;

  // one decoded transaction as it sits in the queue
  typedef struct packed {
    logic [3:0]  command;
    logic [5:0]  reg_index;
    logic [31:0] write_data;
    logic        shift_select;
    logic        low_limit;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] flag_word;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/lcmu_if.sv @@
// ----------------------------------------------------------------------------
// lcmu_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`default_nettype none
interface lcmu_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/lcmu_queue.sv @@
// ----------------------------------------------------------------------------
// lcmu_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module lcmu_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire lcmu_pkg::item_t wdata_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                empty_o,
  output lcmu_pkg::item_t     rdata_o
);
  import lcmu_pkg::*;

  item_t     mem_q [2];
  logic      wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

@@ rtl/lcmu_front.sv @@
// ----------------------------------------------------------------------------
// lcmu_front
// Accepts input transactions, drops unused commands to a no-op read of an
// unmapped register, and pushes them into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module lcmu_front (
  lcmu_if.sink                 in_if,
  input  wire                  full_i,
  output logic                 push_o,
  output lcmu_pkg::item_t      item_o
);
  import lcmu_pkg::*;

  assign in_if.ready = ~full_i;
  assign push_o      = in_if.valid & ~full_i;

  // classify: unused commands become a plain flag report
  always_comb begin
    item_o = in_if.data;
    if (in_if.data.command > CMD_INTERP) begin
      item_o.command   = CMD_READ;
      item_o.reg_index = 6'd63;
    end
  end
endmodule
`default_nettype wire

@@ rtl/lcmu_back.sv @@
// ----------------------------------------------------------------------------
// lcmu_back
// Register file and lighting datapath: three MAC lanes, one pass per item,
// result held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lcmu_back #(
  parameter int unsigned COLOR_QUEUE_DEPTH = 3
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 empty_i,
  input  wire lcmu_pkg::item_t item_i,
  output logic                pop_o,
  lcmu_if.source              out_if
);
  import lcmu_pkg::*;

  localparam int unsigned RiFlags = RI_QUEUE + COLOR_QUEUE_DEPTH;

  logic [15:0] lm_q [9];
  logic [15:0] cm_q [9];
  logic [31:0] bk_q [3];
  logic [31:0] fc_q [3];
  logic [15:0] v0_q [3];
  logic [15:0] ir0_q;
  logic [15:0] ir_q [3];
  logic [31:0] mac_q [3];
  logic [31:0] rgb_q;
  logic [31:0] cq_q [COLOR_QUEUE_DEPTH];
  logic [31:0] flags_q;

  logic        ovalid_q;
  res_t        res_q;

  logic        go;
  logic [31:0] rd;
  logic [31:0] flags_d;
  logic [15:0] ir_d [3];
  logic [31:0] mac_d [3];
  logic        ir_we, push_we;
  logic [31:0] entry;
  int unsigned idx;

  assign go = ~empty_i & (~ovalid_q | out_if.ready);
  assign pop_o = go;
  assign idx = 32'(item_i.reg_index);
  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return 64'($signed(v));
  endfunction
  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    return 64'($signed(v));
  endfunction
  function automatic logic signed [63:0] sar(input logic signed [63:0] v, input logic s);
    return s ? (v >>> 12) : v;
  endfunction

  // register read mux
  always_comb begin
    rd = '0;
    if (idx < 9) rd = 32'(sx16(lm_q[idx[3:0]]));
    else if (idx < 18) rd = 32'(sx16(cm_q[4'(idx - RI_CM)]));
    else if (idx < 21) rd = bk_q[2'(idx - RI_BK)];
    else if (idx < 24) rd = fc_q[2'(idx - RI_FC)];
    else if (idx < 27) rd = 32'(sx16(v0_q[2'(idx - RI_V0)]));
    else if (idx == RI_IR0) rd = 32'(sx16(ir0_q));
    else if (idx < 31) rd = 32'(sx16(ir_q[2'(idx - RI_IR)]));
    else if (idx < 34) rd = mac_q[2'(idx - RI_MAC)];
    else if (idx == RI_RGB) rd = rgb_q;
    else if (idx < RiFlags) begin
      for (int k = 0; k < COLOR_QUEUE_DEPTH; k++)
        if (idx - RI_QUEUE == k) rd = cq_q[k];
    end else if (idx == RiFlags) rd = flags_q;
  end

  // three MAC lanes
  always_comb begin
    logic signed [63:0] acc, lo, v, m, irv, ir0v, c;
    logic [7:0] col;
    flags_d = flags_q;
    ir_we = 1'b0;
    push_we = 1'b0;
    entry = {rgb_q[31:24], 24'd0};
    ir0v = sx16(ir0_q);
    lo = item_i.low_limit ? 64'sd0 : -64'sd32768;
    for (int r = 0; r < 3; r++) begin
      ir_d[r] = ir_q[r];
      mac_d[r] = mac_q[r];
      m = sx32(mac_q[r]);
      irv = sx16(ir_q[r]);
      acc = '0;
      v = '0;
      c = '0;
      col = '0;
      unique case (item_i.command)
        CMD_LIGHT, CMD_CMATRIX: begin
          if (item_i.command == CMD_LIGHT) begin
            acc = sx16(lm_q[3*r]) * sx16(v0_q[0]) + sx16(lm_q[3*r+1]) * sx16(v0_q[1]);
          end else begin
            acc = sx32(bk_q[r]) * 64'sd4096 + sx16(cm_q[3*r]) * sx16(ir_q[0]);
            if (acc > MacHi) flags_d[31-r-1] = 1'b1;
            else if (acc < MacLo) flags_d[28-r-1] = 1'b1;
            acc = acc + sx16(cm_q[3*r+1]) * sx16(ir_q[1]);
          end
          if (acc > MacHi) flags_d[31-r-1] = 1'b1;
          else if (acc < MacLo) flags_d[28-r-1] = 1'b1;
          if (item_i.command == CMD_LIGHT)
            acc = acc + sx16(lm_q[3*r+2]) * sx16(v0_q[2]);
          else
            acc = acc + sx16(cm_q[3*r+2]) * sx16(ir_q[2]);
          if (acc > MacHi) flags_d[31-r-1] = 1'b1;
          else if (acc < MacLo) flags_d[28-r-1] = 1'b1;
          acc = sar(acc, item_i.shift_select);
          v = acc;
          ir_we = 1'b1;
          mac_d[r] = acc[31:0];
        end
        CMD_MODULATE: begin
          acc = $signed({56'd0, rgb_q[8*r +: 8]}) * irv * 64'sd16;
          if (acc > MacHi) flags_d[31-r-1] = 1'b1;
          else if (acc < MacLo) flags_d[28-r-1] = 1'b1;
          mac_d[r] = acc[31:0];
        end
        CMD_FARCOLOR: begin
          acc = m + (sx32(fc_q[r]) - m) * ir0v;
          if (acc > MacHi) flags_d[31-r-1] = 1'b1;
          else if (acc < MacLo) flags_d[28-r-1] = 1'b1;
          mac_d[r] = acc[31:0];
        end
        CMD_SHIFT: begin
          acc = sar(m, item_i.shift_select);
          mac_d[r] = acc[31:0];
        end
        CMD_PUSH: begin
          c = m >>> 4;
          if (c > 64'sd255) begin
            col = 8'hFF;
            flags_d[22-r-1] = 1'b1;
          end else if (c < 64'sd0) begin
            col = 8'h00;
            flags_d[22-r-1] = 1'b1;
          end else begin
            col = c[7:0];
          end
          entry[8*r +: 8] = col;
          v = m;
          ir_we = 1'b1;
          push_we = 1'b1;
        end
        CMD_INTERP: begin
          acc = irv * ir0v + m;
          if (acc > MacHi) flags_d[31-r-1] = 1'b1;
          else if (acc < MacLo) flags_d[28-r-1] = 1'b1;
          acc = sar(acc, item_i.shift_select);
          mac_d[r] = acc[31:0];
        end
        default: ;
      endcase
      // saturate IR
      if (ir_we) begin
        if (v > 64'sd32767) begin
          ir_d[r] = 16'h7FFF;
          flags_d[25-r-1] = 1'b1;
        end else if (v < lo) begin
          ir_d[r] = lo[15:0];
          flags_d[25-r-1] = 1'b1;
        end else begin
          ir_d[r] = v[15:0];
        end
      end
    end
    // route register writes to IR and MAC through the lane next values
    if (item_i.command == CMD_WRITE) begin
      if (idx >= RI_IR && idx < RI_MAC) ir_d[2'(idx - RI_IR)] = item_i.write_data[15:0];
      else if (idx >= RI_MAC && idx < RI_RGB) mac_d[2'(idx - RI_MAC)] = item_i.write_data;
    end
    if (item_i.command == CMD_WRITE && idx == RiFlags) flags_d = item_i.write_data;
  end

  // update registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        lm_q[k] <= '0;
        cm_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        bk_q[k] <= '0;
        fc_q[k] <= '0;
        v0_q[k] <= '0;
        ir_q[k] <= '0;
        mac_q[k] <= '0;
      end
      for (int k = 0; k < COLOR_QUEUE_DEPTH; k++) cq_q[k] <= '0;
      ir0_q <= '0;
      rgb_q <= '0;
      flags_q <= '0;
      ovalid_q <= 1'b0;
      res_q <= '0;
    end else begin
      if (out_if.ready) ovalid_q <= 1'b0;
      if (go) begin
        ovalid_q <= 1'b1;
        res_q.read_data <= (item_i.command == CMD_READ) ? rd : 32'd0;
        res_q.flag_word <= flags_d;
        flags_q <= flags_d;
        for (int k = 0; k < 3; k++) begin
          ir_q[k] <= ir_d[k];
          mac_q[k] <= mac_d[k];
        end
        if (push_we) begin
          for (int k = 0; k + 1 < COLOR_QUEUE_DEPTH; k++) cq_q[k] <= cq_q[k+1];
          cq_q[COLOR_QUEUE_DEPTH-1] <= entry;
        end
        if (item_i.command == CMD_WRITE) begin
          if (idx < 9) lm_q[idx[3:0]] <= item_i.write_data[15:0];
          else if (idx < 18) cm_q[4'(idx - RI_CM)] <= item_i.write_data[15:0];
          else if (idx < 21) bk_q[2'(idx - RI_BK)] <= item_i.write_data;
          else if (idx < 24) fc_q[2'(idx - RI_FC)] <= item_i.write_data;
          else if (idx < 27) v0_q[2'(idx - RI_V0)] <= item_i.write_data[15:0];
          else if (idx == RI_IR0) ir0_q <= item_i.write_data[15:0];
          else if (idx == RI_RGB) rgb_q <= item_i.write_data;
          else if (idx > RI_RGB && idx < RiFlags) begin
            for (int k = 0; k < COLOR_QUEUE_DEPTH; k++)
              if (idx - RI_QUEUE == k) cq_q[k] <= item_i.write_data;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/lighting_color_mac_unit.sv @@
// ----------------------------------------------------------------------------
// lighting_color_mac_unit
// Lighting and color MAC unit with a register file and sticky flags.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries command, reg_index, write_data, shift_select, low_limit.
//   out_if carries read_data and flag_word, one result per input transaction.
//   The front part accepts transactions into a two-entry queue; the back
//   part pops one per cycle while the output register is free or being
//   taken, runs all three MAC lanes in that cycle and loads the output
//   register. Results pass from the queue through the output register.
//   Throughput: 1 transaction per cycle unless the receiver stalls.
//   Reset clears every register, the flags and the queue.
//   When the receiver stalls, the result holds, the queue fills, and then
//   in_if.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none
module lighting_color_mac_unit #(
  parameter int unsigned COLOR_QUEUE_DEPTH = 3
) (
  input wire clk_i,
  input wire rst_ni,
  lcmu_if.sink   in_if,
  lcmu_if.source out_if
);
  import lcmu_pkg::*;

  item_t item_f, item_b;
  logic  full, empty, push, pop;

  lcmu_front u_front (
    .in_if (in_if), .full_i(full), .push_o(push), .item_o(item_f)
  );

  lcmu_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .wdata_i(item_f),
    .full_o(full), .pop_i(pop), .empty_o(empty), .rdata_o(item_b)
  );

  lcmu_back #(.COLOR_QUEUE_DEPTH(COLOR_QUEUE_DEPTH)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .empty_i(empty), .item_i(item_b),
    .pop_o(pop), .out_if(out_if)
  );
endmodule
`default_nettype wire
